### design/dlt_pkg.sv
package dlt_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_ESCAPED = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNTERMINATED = 2'd1,
        ERR_NO_NEWLINE   = 2'd2
    } err_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // One result of the lexer step
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_value;
        logic       token_end;
        logic       line_end;
        err_t       error_code;
    } result_t;

endpackage

### design/directive_line_tokenizer_core.sv
// Path: a request accepted on s_* passes the input register, then the result
// register, before it appears on m_*.
// Throughput: one request per cycle while m_tready is high; the lexer step
// between the two registers sets the rate. A stalled result holds the input once
// the input register is full, so one request can wait there behind it.
// Reset: rst_n clears both pipeline valids and the lexer state to normal mode.
module directive_line_tokenizer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] kind (0 data byte, 1 end of file)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] char_value, [8] line_end,
                                   // [10:9] error_code, [15:11] zero
    output logic        m_tlast,   // token_end
    output logic        m_tuser    // [0] char_valid
);

    // Input register
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [7:0]        in_byte_reg;

    // Result register
    logic              out_valid_reg;
    dlt_pkg::result_t  out_result_reg;

    dlt_pkg::result_t  step_result;
    logic              out_free;
    logic              advance;
    logic              in_take;

    // Result slot frees when empty or being taken downstream
    assign out_free = !out_valid_reg || m_tready;
    // Move the held request through the lexer into the result register
    assign advance  = in_valid_reg && out_free;
    // Take a new request whenever the input register empties this cycle
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    dlt_lexer u_lexer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .kind       (in_kind_reg),
        .byte_value (in_byte_reg),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.char_valid;
    assign m_tlast  = out_result_reg.token_end;
    assign m_tdata  = {5'd0, out_result_reg.error_code, out_result_reg.line_end,
                       out_result_reg.char_value};

    // An end-of-file result carries no token marks
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_result_reg.error_code != dlt_pkg::ERR_NONE)
            |-> (!m_tuser && !m_tlast && !out_result_reg.line_end))
        else $error("end-of-file result carries token marks");

    // Dropped bytes leave a zero character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (out_result_reg.char_value == 8'd0))
        else $error("char_value set without char_valid");

    // A held request is never lost while the result stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("input register dropped a stalled request");

    // A request entering the lexer must find a free result slot
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> out_free)
        else $error("lexer advanced into a full result register");

endmodule

### design/dlt_lexer.sv
module dlt_lexer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               kind,
    input  logic [7:0]         byte_value,
    output dlt_pkg::result_t   result
);

    dlt_pkg::mode_t lexer_mode_reg;
    dlt_pkg::mode_t lexer_mode_next;
    logic           token_open_reg;
    logic           token_open_next;
    logic           line_has_tokens_reg;
    logic           line_has_tokens_next;

    logic is_blank;
    logic is_newline;
    logic has_tokens;

    assign is_newline = (byte_value == dlt_pkg::CH_NEWLINE);
    assign is_blank   = (byte_value == dlt_pkg::CH_SPACE) ||
                        ((byte_value >= dlt_pkg::CH_TAB) && (byte_value <= dlt_pkg::CH_CR));
    // Line counts as holding tokens while a token is open or once one is closed on it
    assign has_tokens = line_has_tokens_reg || token_open_reg;

    always_comb
    begin
        lexer_mode_next      = lexer_mode_reg;
        token_open_next      = token_open_reg;
        line_has_tokens_next = line_has_tokens_reg;
        result               = '0;
        result.error_code    = dlt_pkg::ERR_NONE;

        if (kind)
        begin
            if (lexer_mode_reg != dlt_pkg::MODE_NORMAL)
                result.error_code = dlt_pkg::ERR_UNTERMINATED;
            else if (token_open_reg || line_has_tokens_reg)
                result.error_code = dlt_pkg::ERR_NO_NEWLINE;
            lexer_mode_next      = dlt_pkg::MODE_NORMAL;
            token_open_next      = 1'b0;
            line_has_tokens_next = 1'b0;
        end
        else
        begin
            unique case (lexer_mode_reg)
                dlt_pkg::MODE_NORMAL:
                begin
                    if (byte_value == dlt_pkg::CH_QUOTE)
                    begin
                        token_open_next = 1'b1;
                        lexer_mode_next = dlt_pkg::MODE_STRING;
                    end
                    else if (byte_value == dlt_pkg::CH_SEMI)
                    begin
                        lexer_mode_next = dlt_pkg::MODE_COMMENT;
                    end
                    else if (is_blank)
                    begin
                        result.token_end = token_open_reg;
                        token_open_next  = 1'b0;
                        if (is_newline)
                        begin
                            result.line_end      = has_tokens;
                            line_has_tokens_next = 1'b0;
                        end
                        else
                        begin
                            line_has_tokens_next = has_tokens;
                        end
                    end
                    else
                    begin
                        result.char_valid = 1'b1;
                        result.char_value = byte_value;
                        token_open_next   = 1'b1;
                    end
                end
                dlt_pkg::MODE_STRING:
                begin
                    if (byte_value == dlt_pkg::CH_BACKSLASH)
                        lexer_mode_next = dlt_pkg::MODE_ESCAPED;
                    else if (byte_value == dlt_pkg::CH_QUOTE)
                        lexer_mode_next = dlt_pkg::MODE_NORMAL;
                    else
                    begin
                        result.char_valid = 1'b1;
                        result.char_value = byte_value;
                    end
                end
                dlt_pkg::MODE_ESCAPED:
                begin
                    result.char_valid = 1'b1;
                    result.char_value = byte_value;
                    lexer_mode_next   = dlt_pkg::MODE_STRING;
                end
                dlt_pkg::MODE_COMMENT:
                begin
                    // Drop everything up to the newline, which closes token and line
                    if (is_newline)
                    begin
                        result.token_end     = token_open_reg;
                        result.line_end      = has_tokens;
                        token_open_next      = 1'b0;
                        line_has_tokens_next = 1'b0;
                        lexer_mode_next      = dlt_pkg::MODE_NORMAL;
                    end
                end
                default:
                begin
                    lexer_mode_next = dlt_pkg::MODE_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lexer_mode_reg      <= dlt_pkg::MODE_NORMAL;
            token_open_reg      <= 1'b0;
            line_has_tokens_reg <= 1'b0;
        end
        else if (advance)
        begin
            lexer_mode_reg      <= lexer_mode_next;
            token_open_reg      <= token_open_next;
            line_has_tokens_reg <= line_has_tokens_next;
        end
    end

endmodule
